[rtl/yuyv_to_rgb24_pair_macros.svh]
// ---------------------------------------------------------------------------
// yuyv to rgb24 pair: assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ---------------------------------------------------------------------------
`ifndef YUYV_TO_RGB24_PAIR_MACROS_SVH
`define YUYV_TO_RGB24_PAIR_MACROS_SVH

// antecedent in this cycle implies consequent in the same cycle
`define YRP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must never hold
`define YRP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/yrp_pkg.sv]
// ---------------------------------------------------------------------------
// yrp_pkg: types and constant tables for the yuyv to rgb24 pair converter
// Item structs, chroma term bundle, and the lookup tables built at
// elaboration for studio-range expansion and the bt.601 weights.
// ---------------------------------------------------------------------------
package yrp_pkg;

    // widths
    localparam int BYTE_W      = 8;
    localparam int TBL_DEPTH   = 256;
    localparam int TERM_W      = 10;  // expanded luma and chroma terms
    localparam int NUM_W       = 19;  // green numerator, signed
    localparam int GPART_W     = 18;  // one green partial, signed
    localparam int MAG_W       = 18;  // magnitude of the green numerator
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int SUM_W       = 11;  // luma plus one term

    // ceil(2^28 / 1000), exact for magnitudes below 2^18
    localparam logic [RECIP_W-1:0] GREEN_RECIP = 19'd268436;

    localparam logic [BYTE_W-1:0] CHAN_MAX = 8'd255;

    // input item
    typedef struct packed {
        logic [BYTE_W-1:0] luma_first;
        logic [BYTE_W-1:0] chroma_blue;
        logic [BYTE_W-1:0] luma_second;
        logic [BYTE_W-1:0] chroma_red;
    } pixel_pair_t;

    // one rgb pixel from a lane
    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } pixel_rgb_t;

    // result item
    typedef struct packed {
        logic [BYTE_W-1:0] red_first;
        logic [BYTE_W-1:0] green_first;
        logic [BYTE_W-1:0] blue_first;
        logic [BYTE_W-1:0] red_second;
        logic [BYTE_W-1:0] green_second;
        logic [BYTE_W-1:0] blue_second;
    } rgb_pair_t;

    // chroma contributions shared by both lanes
    typedef struct packed {
        logic signed [TERM_W-1:0] red;
        logic signed [TERM_W-1:0] green;
        logic signed [TERM_W-1:0] blue;
    } chroma_terms_t;

    typedef logic signed [TERM_W-1:0]  term_tbl_t  [TBL_DEPTH];
    typedef logic signed [GPART_W-1:0] gpart_tbl_t [TBL_DEPTH];

    // studio-range chroma expansion, elaboration only
    function automatic int chroma_expand(int c);
        return (255 * (c - 128)) / 224;
    endfunction

    function automatic term_tbl_t build_luma_tbl();
        term_tbl_t t;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            t[i] = TERM_W'((255 * (i - 16)) / 219);
        end
        return t;
    endfunction

    function automatic term_tbl_t build_red_tbl();
        term_tbl_t t;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            t[i] = TERM_W'((1402 * chroma_expand(i)) / 1000);
        end
        return t;
    endfunction

    function automatic term_tbl_t build_blue_tbl();
        term_tbl_t t;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            t[i] = TERM_W'((1772 * chroma_expand(i)) / 1000);
        end
        return t;
    endfunction

    function automatic gpart_tbl_t build_gcb_tbl();
        gpart_tbl_t t;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            t[i] = GPART_W'(-344 * chroma_expand(i));
        end
        return t;
    endfunction

    function automatic gpart_tbl_t build_gcr_tbl();
        gpart_tbl_t t;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            t[i] = GPART_W'(-714 * chroma_expand(i));
        end
        return t;
    endfunction

    localparam term_tbl_t  LUMA_TBL = build_luma_tbl();
    localparam term_tbl_t  RED_TBL  = build_red_tbl();
    localparam term_tbl_t  BLUE_TBL = build_blue_tbl();
    localparam gpart_tbl_t GCB_TBL  = build_gcb_tbl();
    localparam gpart_tbl_t GCR_TBL  = build_gcr_tbl();

endpackage

[rtl/yrp_chroma.sv]
// ---------------------------------------------------------------------------
// yrp_chroma: shared chroma term unit
// Looks up the red and blue terms, forms the green numerator and divides
// it by 1000 toward zero with a reciprocal multiply; each step is registered.
// ---------------------------------------------------------------------------
module yrp_chroma
(
    input  logic                           clk,
    input  logic [yrp_pkg::BYTE_W-1:0]     chroma_blue,
    input  logic [yrp_pkg::BYTE_W-1:0]     chroma_red,
    output yrp_pkg::chroma_terms_t         terms
);

    // stage 1 registers
    logic signed [yrp_pkg::TERM_W-1:0] red_s1_reg;
    logic signed [yrp_pkg::TERM_W-1:0] blue_s1_reg;
    logic signed [yrp_pkg::NUM_W-1:0]  num_s1_reg;
    logic signed [yrp_pkg::NUM_W-1:0]  num_s1_next;

    // stage 2 registers
    logic signed [yrp_pkg::TERM_W-1:0] red_s2_reg;
    logic signed [yrp_pkg::TERM_W-1:0] blue_s2_reg;
    logic                              neg_s2_reg;
    logic [yrp_pkg::PROD_W-1:0]        prod_s2_reg;
    logic [yrp_pkg::MAG_W-1:0]         mag;
    logic [yrp_pkg::PROD_W-1:0]        prod_s2_next;

    // stage 3 registers
    yrp_pkg::chroma_terms_t            terms_reg;
    yrp_pkg::chroma_terms_t            terms_next;
    logic [yrp_pkg::QUOT_W-1:0]        quot;
    logic signed [yrp_pkg::TERM_W-1:0] quot_ext;

    // green numerator from the two partial tables
    assign num_s1_next = yrp_pkg::NUM_W'(yrp_pkg::GCB_TBL[chroma_blue])
                       + yrp_pkg::NUM_W'(yrp_pkg::GCR_TBL[chroma_red]);

    always_ff @(posedge clk)
    begin
        red_s1_reg  <= yrp_pkg::RED_TBL[chroma_red];
        blue_s1_reg <= yrp_pkg::BLUE_TBL[chroma_blue];
        num_s1_reg  <= num_s1_next;
    end

    // magnitude times reciprocal
    always_comb
    begin
        if (num_s1_reg[yrp_pkg::NUM_W-1])
        begin
            mag = yrp_pkg::MAG_W'(-num_s1_reg);
        end
        else
        begin
            mag = yrp_pkg::MAG_W'(num_s1_reg);
        end
        prod_s2_next = yrp_pkg::PROD_W'(mag) * yrp_pkg::PROD_W'(yrp_pkg::GREEN_RECIP);
    end

    always_ff @(posedge clk)
    begin
        red_s2_reg  <= red_s1_reg;
        blue_s2_reg <= blue_s1_reg;
        neg_s2_reg  <= num_s1_reg[yrp_pkg::NUM_W-1];
        prod_s2_reg <= prod_s2_next;
    end

    // quotient with the sign restored
    always_comb
    begin
        quot     = prod_s2_reg[yrp_pkg::PROD_W-1:yrp_pkg::RECIP_SHIFT];
        quot_ext = $signed(yrp_pkg::TERM_W'(quot));
        terms_next.red   = red_s2_reg;
        terms_next.blue  = blue_s2_reg;
        if (neg_s2_reg)
        begin
            terms_next.green = -quot_ext;
        end
        else
        begin
            terms_next.green = quot_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        terms_reg <= terms_next;
    end

    assign terms = terms_reg;

endmodule

[rtl/yrp_lane.sv]
// ---------------------------------------------------------------------------
// yrp_lane: one pixel lane
// Expands the luma byte, holds it alongside the chroma unit, then adds
// each chroma term and clamps the three channels to 0..255.
// ---------------------------------------------------------------------------
module yrp_lane
(
    input  logic                       clk,
    input  logic [yrp_pkg::BYTE_W-1:0] luma,
    input  yrp_pkg::chroma_terms_t     terms,
    output yrp_pkg::pixel_rgb_t        pixel
);

    logic signed [yrp_pkg::TERM_W-1:0] luma_s1_reg;
    logic signed [yrp_pkg::TERM_W-1:0] luma_s2_reg;
    logic signed [yrp_pkg::TERM_W-1:0] luma_s3_reg;
    logic signed [yrp_pkg::SUM_W-1:0]  red_sum;
    logic signed [yrp_pkg::SUM_W-1:0]  green_sum;
    logic signed [yrp_pkg::SUM_W-1:0]  blue_sum;

    // saturate a channel sum to one byte
    function automatic logic [yrp_pkg::BYTE_W-1:0] clamp(logic signed [yrp_pkg::SUM_W-1:0] v);
        logic [yrp_pkg::BYTE_W-1:0] r;
        if (v[yrp_pkg::SUM_W-1])
        begin
            r = '0;
        end
        else if (v > $signed(yrp_pkg::SUM_W'(yrp_pkg::CHAN_MAX)))
        begin
            r = yrp_pkg::CHAN_MAX;
        end
        else
        begin
            r = v[yrp_pkg::BYTE_W-1:0];
        end
        return r;
    endfunction

    // luma expansion, delayed to meet the chroma terms
    always_ff @(posedge clk)
    begin
        luma_s1_reg <= yrp_pkg::LUMA_TBL[luma];
        luma_s2_reg <= luma_s1_reg;
        luma_s3_reg <= luma_s2_reg;
    end

    // channel sums and saturation
    always_comb
    begin
        red_sum     = yrp_pkg::SUM_W'(luma_s3_reg) + yrp_pkg::SUM_W'(terms.red);
        green_sum   = yrp_pkg::SUM_W'(luma_s3_reg) + yrp_pkg::SUM_W'(terms.green);
        blue_sum    = yrp_pkg::SUM_W'(luma_s3_reg) + yrp_pkg::SUM_W'(terms.blue);
        pixel.red   = clamp(red_sum);
        pixel.green = clamp(green_sum);
        pixel.blue  = clamp(blue_sum);
    end

endmodule

[rtl/yuyv_to_rgb24_pair.sv]
// ---------------------------------------------------------------------------
// yuyv_to_rgb24_pair: yuyv macropixel to two rgb24 pixels
// A shared chroma unit feeds two pixel lanes; an output register merges
// the lanes into one result item.
//
//   channel  | handshake       | payload
//   ---------+-----------------+---------------------------
//   input    | start / busy    | pixel_pair (pixel_pair_t)
//   result   | done strobe     | rgb_pair (rgb_pair_t)
//
// One item per clock; busy never rises. Each result passes through the
// chroma unit's registers (lookup, reciprocal multiply, sign restore)
// and then the merging output register. Reset clears only the valid
// pipeline and the done strobe; results show on done for a single cycle
// and the receiver cannot stall them.
// ---------------------------------------------------------------------------
`include "yuyv_to_rgb24_pair_macros.svh"

module yuyv_to_rgb24_pair
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  yrp_pkg::pixel_pair_t pixel_pair,
    output logic                 done,
    output yrp_pkg::rgb_pair_t   rgb_pair
);

    localparam int PIPE_D = 3;

    logic [PIPE_D-1:0]      vld_reg;
    logic [PIPE_D-1:0]      vld_next;
    logic                   done_reg;
    logic                   done_next;
    yrp_pkg::rgb_pair_t     rgb_reg;
    yrp_pkg::rgb_pair_t     rgb_next;
    yrp_pkg::chroma_terms_t terms;
    yrp_pkg::pixel_rgb_t    pixel_first;
    yrp_pkg::pixel_rgb_t    pixel_second;

    // full rate, never stalls
    assign busy = 1'b0;

    // shared chroma unit
    yrp_chroma u_chroma
    (
        .clk         (clk),
        .chroma_blue (pixel_pair.chroma_blue),
        .chroma_red  (pixel_pair.chroma_red),
        .terms       (terms)
    );

    // pixel lanes
    yrp_lane u_lane_first
    (
        .clk   (clk),
        .luma  (pixel_pair.luma_first),
        .terms (terms),
        .pixel (pixel_first)
    );

    yrp_lane u_lane_second
    (
        .clk   (clk),
        .luma  (pixel_pair.luma_second),
        .terms (terms),
        .pixel (pixel_second)
    );

    // valid pipeline and strobe
    assign vld_next  = {vld_reg[PIPE_D-2:0], start & ~busy};
    assign done_next = vld_reg[PIPE_D-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= done_next;
        end
    end

    // merge the lanes into the result item
    always_comb
    begin
        rgb_next.red_first    = pixel_first.red;
        rgb_next.green_first  = pixel_first.green;
        rgb_next.blue_first   = pixel_first.blue;
        rgb_next.red_second   = pixel_second.red;
        rgb_next.green_second = pixel_second.green;
        rgb_next.blue_second  = pixel_second.blue;
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign done     = done_reg;
    assign rgb_pair = rgb_reg;

    // checks
    `YRP_ASSERT_NEVER(a_done_has_item, done && !$past(start && !busy, 4), "result without item")
    `YRP_ASSERT_IMPLY(a_lanes_agree, done && ($past(pixel_pair.luma_first, 4) == $past(pixel_pair.luma_second, 4)), (rgb_pair.red_first == rgb_pair.red_second) && (rgb_pair.green_first == rgb_pair.green_second) && (rgb_pair.blue_first == rgb_pair.blue_second), "lanes disagree on equal luma")
    `YRP_ASSERT_IMPLY(a_neutral_gray, done && ($past(pixel_pair.chroma_blue, 4) == 8'd128) && ($past(pixel_pair.chroma_red, 4) == 8'd128), (rgb_pair.red_first == rgb_pair.green_first) && (rgb_pair.green_first == rgb_pair.blue_first), "neutral chroma not gray")

endmodule
